// ----- rtl/core/lru_kv_pkg.sv -----
// shared constants, types and result records for the lru key-value cache
package lru_kv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int WORD_W      = 32;
    localparam int CAP_W       = 5;
    localparam int AGE_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [MAX_ENTRIES-1:0]   t_mask;
    typedef logic [AGE_W-1:0]         t_age;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CAP_W-1:0]         t_cap;
    typedef logic [EXT_W-1:0]         t_ext;

    localparam logic  CMD_GET   = 1'b0;
    localparam logic  CMD_PUT   = 1'b1;
    localparam t_cap  CAP_RESET = t_cap'(16);
    localparam t_word READ_MISS = -32'sd1;

    // slot update decided for one beat
    typedef struct packed {
        t_mask tgt;      // slot written and made most recent
        t_mask inc;      // slots that age by one
        logic  wr_key;
        logic  wr_data;
        logic  cnt_inc;
    } t_upd;

    typedef struct packed {
        logic  hit;
        t_word read_value;
        logic  evicted;
        t_word evicted_key;
    } t_result;

endpackage

// ----- rtl/core/lru_kv_store.sv -----
// slot storage: valid bits, keys, values, recency ranks and live count
module lru_kv_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lru_kv_pkg::t_upd     i_upd,
    input  lru_kv_pkg::t_word    i_key,
    input  lru_kv_pkg::t_word    i_data,
    output lru_kv_pkg::t_mask    o_valid,
    output lru_kv_pkg::t_word    o_keys [lru_kv_pkg::MAX_ENTRIES],
    output lru_kv_pkg::t_word    o_datas [lru_kv_pkg::MAX_ENTRIES],
    output lru_kv_pkg::t_age     o_ages [lru_kv_pkg::MAX_ENTRIES],
    output lru_kv_pkg::t_cnt     o_live
);
    import lru_kv_pkg::*;

    t_mask r_valid;
    t_word r_keys  [MAX_ENTRIES];
    t_word r_datas [MAX_ENTRIES];
    t_age  r_ages  [MAX_ENTRIES];
    t_cnt  r_live;

    // control state: valid bits, ranks, count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_ages[i] <= '0;
            end
        end else begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (i_upd.tgt[i]) begin
                    r_valid[i] <= 1'b1;
                    r_ages[i]  <= '0;
                end else if (i_upd.inc[i]) begin
                    r_ages[i]  <= r_ages[i] + t_age'(1);
                end
            end
            if (i_upd.cnt_inc) begin
                r_live <= r_live + t_cnt'(1);
            end
        end
    end

    // payload: keys and values
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i_upd.tgt[i] && i_upd.wr_key) begin
                r_keys[i] <= i_key;
            end
            if (i_upd.tgt[i] && i_upd.wr_data) begin
                r_datas[i] <= i_data;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_keys  = r_keys;
    assign o_datas = r_datas;
    assign o_ages  = r_ages;
    assign o_live  = r_live;

endmodule

// ----- rtl/core/lru_kv_decide.sv -----
// parallel key match, victim and free slot pick, rank update and result
module lru_kv_decide (
    input  logic                 i_valid,
    input  logic                 i_cmd,
    input  lru_kv_pkg::t_word    i_key,
    input  lru_kv_pkg::t_word    i_data_in,
    input  lru_kv_pkg::t_cap     i_capacity,
    input  lru_kv_pkg::t_mask    i_slot_valid,
    input  lru_kv_pkg::t_word    i_keys [lru_kv_pkg::MAX_ENTRIES],
    input  lru_kv_pkg::t_word    i_datas [lru_kv_pkg::MAX_ENTRIES],
    input  lru_kv_pkg::t_age     i_ages [lru_kv_pkg::MAX_ENTRIES],
    input  lru_kv_pkg::t_cnt     i_live,
    output lru_kv_pkg::t_upd     o_upd,
    output lru_kv_pkg::t_result  o_res
);
    import lru_kv_pkg::*;

    t_mask match;
    t_mask lru_oh;
    t_mask inv;
    t_mask free_oh;
    t_mask tgt;
    t_word hit_data;
    t_word evk;
    t_age  hit_age;
    t_ext  cap_eff;
    logic  hit;
    logic  is_put;
    logic  any_free;
    logic  evict;
    logic  insert;

    always_comb begin
        match    = '0;
        lru_oh   = '0;
        hit_data = '0;
        hit_age  = '0;
        evk      = '0;
        // keys are unique among live slots, ranks are distinct: one-hot selects
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match[i]  = i_slot_valid[i] && (i_keys[i] == i_key);
            lru_oh[i] = i_slot_valid[i] && (t_cnt'(i_ages[i]) == (i_live - t_cnt'(1)));
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match[i]) begin
                hit_data = hit_data | i_datas[i];
                hit_age  = hit_age | i_ages[i];
            end
            if (lru_oh[i]) begin
                evk = evk | i_keys[i];
            end
        end
        // lowest free slot
        inv      = ~i_slot_valid;
        free_oh  = inv & (~inv + t_mask'(1));
        any_free = |inv;

        // capacity clamped to 1 .. MAX_ENTRIES
        cap_eff = t_ext'(i_capacity);
        if (cap_eff == '0) begin
            cap_eff = t_ext'(1);
        end else if (cap_eff > t_ext'(MAX_ENTRIES)) begin
            cap_eff = t_ext'(MAX_ENTRIES);
        end

        hit    = i_valid && (|match);
        is_put = i_valid && (i_cmd == CMD_PUT);
        evict  = is_put && !hit && ((t_ext'(i_live) >= cap_eff) || !any_free);
        insert = is_put && !hit && !evict;

        if (hit) begin
            tgt = match;
        end else if (evict) begin
            tgt = lru_oh;
        end else if (insert) begin
            tgt = free_oh;
        end else begin
            tgt = '0;
        end

        o_upd.tgt = tgt;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            o_upd.inc[i] = (|tgt) && i_slot_valid[i] && !tgt[i]
                           && (!hit || (i_ages[i] < hit_age));
        end
        o_upd.wr_key  = is_put && !hit;
        o_upd.wr_data = is_put;
        o_upd.cnt_inc = insert;

        o_res.hit = hit;
        if (i_cmd == CMD_PUT) begin
            o_res.read_value = i_data_in;
        end else if (hit) begin
            o_res.read_value = hit_data;
        end else begin
            o_res.read_value = READ_MISS;
        end
        o_res.evicted     = evict;
        o_res.evicted_key = evict ? evk : '0;
    end

endmodule

// ----- rtl/core/lru_key_value_cache_core.sv -----
// top level of the fully associative lru key-value cache
//
//  channel   | signals                                   | direction | handshake
//  ----------+-------------------------------------------+-----------+------------------------
//  command   | i_start, o_busy, i_cmd, i_key, i_data_in  | in        | start && !busy
//  result    | o_result_valid, o_hit, o_read_value,      | out       | one-cycle strobe,
//            | o_evicted, o_evicted_key                  |           | no back-pressure
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_data      | in        | valid && ready
//
//  a command beat is taken every cycle (busy stays low); it waits in the input
//  register, then the match / rank logic feeds the result register and the slot
//  store together
//  the next beat sees the slot store already updated by the one before it
//  reset (synchronous, active low) empties all slots and sets capacity to 16
//  the receiver cannot stall, so nothing ever holds the command side back
module lru_key_value_cache_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic                   i_cmd,
    input  lru_kv_pkg::t_word      i_key,
    input  lru_kv_pkg::t_word      i_data_in,
    // result channel
    output logic                   o_result_valid,
    output logic                   o_hit,
    output lru_kv_pkg::t_word      o_read_value,
    output logic                   o_evicted,
    output lru_kv_pkg::t_word      o_evicted_key,
    // capacity register write channel
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  lru_kv_pkg::t_cap       i_cfg_data
);
    import lru_kv_pkg::*;

    // input register
    logic    r_in_valid;
    logic    r_in_cmd;
    t_word   r_in_key;
    t_word   r_in_data;

    // capacity register
    t_cap    r_capacity;

    // result register
    logic    r_out_valid;
    t_result r_res;
    t_result n_res;

    // slot store view
    t_upd    upd;
    t_mask   slot_valid;
    t_word   slot_keys  [MAX_ENTRIES];
    t_word   slot_datas [MAX_ENTRIES];
    t_age    slot_ages  [MAX_ENTRIES];
    t_cnt    live;

    // the pipe never stops, so both inbound channels are always open
    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // control: beat valid bits and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_capacity  <= CAP_RESET;
        end else begin
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_data;
            end
        end
    end

    // payload: command fields and result fields
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_in_cmd  <= i_cmd;
            r_in_key  <= i_key;
            r_in_data <= i_data_in;
        end
        r_res <= n_res;
    end

    // lookup, victim pick and rank update for the registered beat
    lru_kv_decide u_decide (
        .i_valid      (r_in_valid),
        .i_cmd        (r_in_cmd),
        .i_key        (r_in_key),
        .i_data_in    (r_in_data),
        .i_capacity   (r_capacity),
        .i_slot_valid (slot_valid),
        .i_keys       (slot_keys),
        .i_datas      (slot_datas),
        .i_ages       (slot_ages),
        .i_live       (live),
        .o_upd        (upd),
        .o_res        (n_res)
    );

    // slot state, written at the same edge the result is registered
    lru_kv_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .i_key   (r_in_key),
        .i_data  (r_in_data),
        .o_valid (slot_valid),
        .o_keys  (slot_keys),
        .o_datas (slot_datas),
        .o_ages  (slot_ages),
        .o_live  (live)
    );

    assign o_result_valid = r_out_valid;
    assign o_hit          = r_res.hit;
    assign o_read_value   = r_res.read_value;
    assign o_evicted      = r_res.evicted;
    assign o_evicted_key  = r_res.evicted_key;

endmodule

// ----- verif/lru_key_value_cache_core_tb.sv -----
// self-checking testbench for the lru key-value cache core
`timescale 1ns / 100ps

module lru_key_value_cache_core_tb;
    import lru_kv_pkg::*;

    localparam int    STALL_LIMIT     = 256;   // cycles with no beat of any kind
    localparam int    N_PHASES        = 7;
    localparam int    ITEMS_PER_PHASE = 64;
    localparam int    KEY_POOL_SIZE   = 20;    // more keys than slots, so evictions happen
    localparam int    DRAIN_CYCLES    = 4;     // wait after the last owed result, before a capacity write or the end
    localparam t_word WORD_MIN        = 32'sh8000_0000;
    localparam t_word WORD_MAX        = 32'sh7FFF_FFFF;

    typedef enum logic { ROW_OP, ROW_CAP } t_row_kind;

    // one directed step: a command beat or a capacity write
    typedef struct {
        t_row_kind kind;
        logic      cmd;
        t_word     key;
        t_word     data;
        t_cap      cap;
        bit        lit;    // use the typed-in response instead of the predictor
        t_result   want;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    logic    o_busy;
    logic    i_cmd;
    t_word   i_key;
    t_word   i_data_in;
    logic    o_result_valid;
    logic    o_hit;
    t_word   o_read_value;
    logic    o_evicted;
    t_word   o_evicted_key;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    t_cap    i_cfg_data;

    // shadow copy of the slot table and the capacity register
    bit      shadow_valid [MAX_ENTRIES];
    t_word   shadow_key   [MAX_ENTRIES];
    t_word   shadow_data  [MAX_ENTRIES];
    int      shadow_age   [MAX_ENTRIES];
    int      shadow_live;
    t_cap    shadow_cap;

    t_result  due_responses [$];   // responses owed by the cache, oldest first
    t_dir_row dir_rows      [$];
    t_word    key_pool      [KEY_POOL_SIZE];
    int       err_cnt;

    lru_key_value_cache_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_key          (i_key),
        .i_data_in      (i_data_in),
        .o_result_valid (o_result_valid),
        .o_hit          (o_hit),
        .o_read_value   (o_read_value),
        .o_evicted      (o_evicted),
        .o_evicted_key  (o_evicted_key),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // make slot s most recent; valid slots younger than it age by one
    function automatic void promote_slot(int s, bit was_valid);
        int rank;
        rank = was_valid ? shadow_age[s] : MAX_ENTRIES;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i != s && shadow_valid[i] && shadow_age[i] < rank)
                shadow_age[i] = shadow_age[i] + 1;
        end
        shadow_age[s]   = 0;
        shadow_valid[s] = 1'b1;
    endfunction

    // apply one get/put to the shadow table and return the cache response
    function automatic t_result lru_lookup_update(logic cmd, t_word key, t_word data);
        int      found;
        int      free_slot;
        int      lru;
        int      eff_cap;
        t_result r;
        found     = -1;
        free_slot = -1;
        lru       = -1;
        r         = '0;
        // zero acts as one, anything past the table size saturates
        eff_cap = int'(shadow_cap);
        if (eff_cap == 0) eff_cap = 1;
        if (eff_cap > MAX_ENTRIES) eff_cap = MAX_ENTRIES;

        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                if (found < 0 && shadow_key[i] == key) found = i;
                if (lru < 0 || shadow_age[i] > shadow_age[lru]) lru = i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end

        if (found >= 0) begin
            r.hit = 1'b1;
            if (cmd == CMD_PUT) shadow_data[found] = data;
            r.read_value = shadow_data[found];
            promote_slot(found, 1'b1);
        end else if (cmd == CMD_GET) begin
            r.read_value = READ_MISS;
        end else begin
            r.read_value = data;
            // at or over capacity (capacity may have dropped below the live count)
            if (shadow_live >= eff_cap || free_slot < 0) begin
                if (lru >= 0) begin
                    r.evicted       = 1'b1;
                    r.evicted_key   = shadow_key[lru];
                    shadow_key[lru]  = key;
                    shadow_data[lru] = data;
                    promote_slot(lru, 1'b1);
                end
            end else begin
                shadow_key[free_slot]  = key;
                shadow_data[free_slot] = data;
                promote_slot(free_slot, 1'b0);
                shadow_live = shadow_live + 1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table builders
    // ------------------------------------------------------------------

    function automatic t_dir_row op_row(logic cmd, t_word key, t_word data);
        t_dir_row row;
        row = '{kind: ROW_OP, cmd: cmd, key: key, data: data, cap: '0, lit: 1'b0, want: '0};
        return row;
    endfunction

    function automatic t_dir_row lit_row(logic cmd, t_word key, t_word data, t_result want);
        t_dir_row row;
        row      = op_row(cmd, key, data);
        row.lit  = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_dir_row cap_row(t_cap v);
        t_dir_row row;
        row     = op_row(CMD_GET, '0, '0);
        row.kind = ROW_CAP;
        row.cap  = v;
        return row;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic field_check(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
        if (got !== want)
            report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // results are a one-cycle strobe; compare each with the oldest owed response
    always @(posedge i_clk) begin : resp_mon
        t_result w;
        if (i_rst_n && o_result_valid) begin
            if (due_responses.size() == 0) begin
                report("result beat with no pending command");
            end else begin
                w = due_responses.pop_front();
                field_check("hit",         o_hit,         w.hit);
                field_check("read_value",  o_read_value,  w.read_value);
                field_check("evicted",     o_evicted,     w.evicted);
                field_check("evicted_key", o_evicted_key, w.evicted_key);
            end
        end
    end

    // watchdog: end the run after too many cycles without any beat
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------

    // present one command beat and hold it until accepted; start stays high
    task automatic issue(logic cmd, t_word key, t_word data, bit lit, t_result want);
        t_result predicted;
        i_start   <= 1'b1;
        i_cmd     <= cmd;
        i_key     <= key;
        i_data_in <= data;
        do @(posedge i_clk); while (o_busy);
        predicted = lru_lookup_update(cmd, key, data);
        due_responses.push_back(lit ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic idle_cmd(int n);
        i_start <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // capacity write only once the cache has gone quiet
    task automatic write_capacity(t_cap v);
        i_start <= 1'b0;
        while (due_responses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_cap = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        t_cap  phase_cap;
        logic  cmd;
        t_word key;
        t_word data;

        // known values on every input from time zero
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = CMD_GET;
        i_key       = '0;
        i_data_in   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        err_cnt     = 0;

        // shadow reset: empty table, capacity 16
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_data[i]  = '0;
            shadow_age[i]   = 0;
        end
        shadow_live = 0;
        shadow_cap  = CAP_RESET;

        // key pool: extremes plus random keys
        key_pool[0] = WORD_MIN;
        key_pool[1] = WORD_MAX;
        key_pool[2] = '0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = t_word'($urandom);

        // directed part: misses on an empty cache, extremes of key and value,
        // overwrite, capacity below the live count, zero and oversized capacity
        dir_rows.push_back(lit_row(CMD_GET, '0,       '0,       '{1'b0, READ_MISS, 1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_GET, WORD_MIN, WORD_MAX, '{1'b0, READ_MISS, 1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_PUT, WORD_MAX, WORD_MIN, '{1'b0, WORD_MIN,  1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_PUT, WORD_MIN, WORD_MAX, '{1'b0, WORD_MAX,  1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_GET, WORD_MAX, '0,       '{1'b1, WORD_MIN,  1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_GET, WORD_MIN, '0,       '{1'b1, WORD_MAX,  1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_PUT, WORD_MAX, -32'sd1,  '{1'b1, -32'sd1,   1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_PUT, '0,       '0,       '{1'b0, '0,        1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_GET, '0,       -32'sd1,  '{1'b1, '0,        1'b0, '0}));
        dir_rows.push_back(lit_row(CMD_GET, -32'sd1,  '0,       '{1'b0, READ_MISS, 1'b0, '0}));
        // three live entries, capacity drops to one: each insert evicts one
        dir_rows.push_back(cap_row(t_cap'(1)));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd5, 32'sd55));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd6, 32'sd66));
        dir_rows.push_back(op_row(CMD_GET, 32'sd5, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'sd6, '0));
        // zero capacity behaves as one
        dir_rows.push_back(cap_row(t_cap'(0)));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd7, 32'sd77));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd7, 32'sd88));
        dir_rows.push_back(op_row(CMD_GET, WORD_MAX, '0));
        // largest register value saturates to the table size
        dir_rows.push_back(cap_row(t_cap'(31)));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd1, 32'sd11));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd2, 32'sd22));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd3, 32'sd33));
        dir_rows.push_back(cap_row(t_cap'(17)));
        dir_rows.push_back(op_row(CMD_PUT, 32'sd4, 32'sd44));
        dir_rows.push_back(op_row(CMD_GET, 32'sd1, '0));
        dir_rows.push_back(op_row(CMD_GET, 32'sd7, '0));

        // hold reset, then release it at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CAP)
                write_capacity(dir_rows[r].cap);
            else
                issue(dir_rows[r].cmd, dir_rows[r].key, dir_rows[r].data,
                      dir_rows[r].lit, dir_rows[r].want);
            if ($urandom_range(0, 3) == 0) idle_cmd($urandom_range(1, 4));
        end

        // random part: a capacity per phase, extremes among them;
        // the last phase runs back to back with no gaps
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       phase_cap = t_cap'(16);
                1:       phase_cap = t_cap'(4);
                2:       phase_cap = t_cap'(0);
                3:       phase_cap = t_cap'(31);
                4:       phase_cap = t_cap'(1);
                5:       phase_cap = t_cap'(17);
                default: phase_cap = t_cap'($urandom_range(2, 15));
            endcase
            write_capacity(phase_cap);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                cmd  = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
                // mostly pool keys so hits and evictions are frequent
                if ($urandom_range(0, 4) == 0)
                    key = t_word'($urandom);
                else
                    key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
                data = t_word'($urandom);
                issue(cmd, key, data, 1'b0, '0);
                if (ph != N_PHASES - 1 && $urandom_range(0, 3) == 0)
                    idle_cmd($urandom_range(1, 4));
            end
        end

        // drain: wait for every owed response, then let the pipe settle
        i_start <= 1'b0;
        while (due_responses.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lru_kv_pkg.sv
rtl/core/lru_kv_store.sv
rtl/core/lru_kv_decide.sv
rtl/core/lru_key_value_cache_core.sv
verif/lru_key_value_cache_core_tb.sv
